@@ src/trfr_pkg.sv @@
// ----------------------------------------------------------------------------
// trfr_pkg: shared types and constants of the triangle fan rasterizer
// Field widths, fixed-point sizes, command and status bundles between the
// controller and the datapath, and small helper functions.
// ----------------------------------------------------------------------------
package trfr_pkg;

	// geometry and fixed point
	localparam int MAX_VERTICES_DEF = 8;
	localparam int MAX_DIM          = 1024;
	localparam int FRAC_BITS        = 4;
	localparam int MIN_FACE         = 3;
	localparam int PIXW             = $clog2(MAX_DIM);
	localparam int DIMW             = PIXW + 1;
	localparam int VW               = 16;
	localparam int COLW             = 8;
	localparam int NIBW             = 4;
	localparam int FCOLW            = 3 * NIBW;
	localparam int WORDW            = 16;
	localparam int HALF_PIX         = 2 ** FRAC_BITS;
	localparam int ROUND_UP         = 2 ** FRAC_BITS - 1;

	// datapath word sizes
	localparam int CXW  = PIXW + FRAC_BITS + 1;                 // doubled pixel centre
	localparam int DVW  = VW + 1;                               // doubled vertex
	localparam int DXW  = ((CXW + 1 > DVW) ? CXW + 1 : DVW) + 1; // centre minus vertex
	localparam int LW   = VW + 2;                               // doubled edge delta
	localparam int PW   = DXW + LW;                             // one product
	localparam int EW   = PW + 2;                               // edge function value
	localparam int EDGES     = 3;
	localparam int MUL_TERMS = 2 * EDGES;
	localparam int MSELW     = $clog2(MUL_TERMS);

	// stream packing
	localparam int IN_DATA_W  = ((2 * VW + 3 * COLW + 7) / 8) * 8;
	localparam int OUT_FLDW   = 2 * PIXW + WORDW;
	localparam int OUT_DATA_W = ((OUT_FLDW + 7) / 8) * 8;
	localparam int OUT_PAD    = OUT_DATA_W - OUT_FLDW;
	localparam int IN_USER_W  = 1;
	localparam int OUT_USER_W = 2;

	// configuration registers
	localparam int CFG_IW = 1;
	localparam logic [CFG_IW-1:0] CFG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IW-1:0] CFG_FRAME_HEIGHT = 1'b1;
	localparam logic [DIMW-1:0]   FRAME_W_RST      = DIMW'(384);
	localparam logic [DIMW-1:0]   FRAME_H_RST      = DIMW'(256);

	// input command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	typedef enum logic [1:0] {
		RD_V0,
		RD_PREV,
		RD_CUR
	} rd_sel_t;

	typedef enum logic [1:0] {
		LD_NONE,
		LD_A,
		LD_B,
		LD_C
	} ld_sel_t;

	typedef struct packed {
		logic             capture;
		logic             exec;
		logic             box;
		logic             rd_en;
		rd_sel_t          rd_sel;
		ld_sel_t          ld_sel;
		logic             edge_latch;
		logic             mul_en;
		logic [MSELW-1:0] mul_sel;
	} trfr_cmd_t;

	typedef struct packed {
		logic close_good;
		logic tri_next;
		logic out_free;
	} trfr_sts_t;

	// last valid pixel index for a frame size register (0 acts as 1)
	function automatic logic [PIXW-1:0] frame_limit(input logic [DIMW-1:0] r);
		logic [DIMW-1:0] tmp;
		tmp = r - DIMW'(1);
		if (r == '0) begin
			return '0;
		end else if (r > DIMW'(MAX_DIM)) begin
			return PIXW'(MAX_DIM - 1);
		end
		return tmp[PIXW-1:0];
	endfunction

	// clamp a whole-pixel coordinate into 0 .. lim
	function automatic logic [PIXW-1:0] clamp_pix(input logic signed [VW:0] v,
			input logic [PIXW-1:0] lim);
		logic signed [VW:0] lim_s;
		lim_s = $signed({{(VW + 1 - PIXW){1'b0}}, lim});
		if (v < 0) begin
			return '0;
		end else if (v > lim_s) begin
			return lim;
		end
		return v[PIXW-1:0];
	endfunction

endpackage

@@ src/trfr_ram.sv @@
// ----------------------------------------------------------------------------
// trfr_ram: generic single-port-write, registered-read RAM
// One write and one read per cycle; read data appears the cycle after rd_en.
// ----------------------------------------------------------------------------
module trfr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ src/trfr_ctrl.sv @@
// ----------------------------------------------------------------------------
// trfr_ctrl: sequencer of the triangle fan rasterizer
// Takes one item at a time, runs it in the datapath, then walks box setup
// (good close), vertex fetch and edge-function setup for a new fan triangle.
// ----------------------------------------------------------------------------
module trfr_ctrl
	import trfr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  trfr_sts_t sts,
	output trfr_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_BOX,
		ST_RD_V0,
		ST_RD_PREV,
		ST_RD_CUR,
		ST_LD_CUR,
		ST_EDGE,
		ST_MUL,
		ST_ACC
	} state_t;

	localparam logic [MSELW-1:0] MUL_LAST = MSELW'(MUL_TERMS - 1);

	state_t           state_q;
	logic [MSELW-1:0] term_q;

	// state register and product term counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			term_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (sts.out_free) begin
						if (sts.close_good) begin
							state_q <= ST_BOX;
						end else if (sts.tri_next) begin
							state_q <= ST_RD_V0;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_BOX:     state_q <= ST_RD_V0;
				ST_RD_V0:   state_q <= ST_RD_PREV;
				ST_RD_PREV: state_q <= ST_RD_CUR;
				ST_RD_CUR:  state_q <= ST_LD_CUR;
				ST_LD_CUR:  state_q <= ST_EDGE;
				ST_EDGE: begin
					state_q <= ST_MUL;
					term_q  <= '0;
				end
				ST_MUL: begin
					if (term_q == MUL_LAST) begin
						state_q <= ST_ACC;
					end else begin
						term_q <= term_q + MSELW'(1);
					end
				end
				ST_ACC:  state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	// datapath commands per state
	always_comb begin
		cmd            = '0;
		cmd.rd_sel     = RD_V0;
		cmd.ld_sel     = LD_NONE;
		cmd.capture    = s_tvalid && s_tready;
		cmd.mul_sel    = term_q;
		case (state_q)
			ST_EXEC: cmd.exec = sts.out_free;
			ST_BOX:  cmd.box = 1'b1;
			ST_RD_V0: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_V0;
			end
			ST_RD_PREV: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_PREV;
				cmd.ld_sel = LD_A;
			end
			ST_RD_CUR: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_CUR;
				cmd.ld_sel = LD_B;
			end
			ST_LD_CUR: cmd.ld_sel = LD_C;
			ST_EDGE:   cmd.edge_latch = 1'b1;
			ST_MUL:    cmd.mul_en = 1'b1;
			default: begin
			end
		endcase
	end

endmodule

@@ src/trfr_dp.sv @@
// ----------------------------------------------------------------------------
// trfr_dp: datapath of the triangle fan rasterizer
// Vertex RAM, running bounding box, per-triangle edge-function setup on one
// shared multiplier, incremental edge stepping, configuration registers and
// the output register.
// ----------------------------------------------------------------------------
module trfr_dp
	import trfr_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  trfr_cmd_t             cmd,
	output trfr_sts_t             sts,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [IN_USER_W-1:0]  s_tuser,
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [OUT_USER_W-1:0] m_tuser,
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IW-1:0]     cfg_index,
	input  logic [DIMW-1:0]       cfg_data
);

	localparam int AW   = $clog2(MAX_VERTICES);
	localparam int CNTW = $clog2(MAX_VERTICES + 2);

	// captured item
	logic                 in_cmd_q;
	logic signed [VW-1:0] in_x_q, in_y_q;
	logic [COLW-1:0]      in_r_q, in_g_q, in_b_q;
	logic                 in_last_q;

	// face state
	logic [DIMW-1:0]      frame_w_q, frame_h_q;
	logic [CNTW-1:0]      count_q, fan_q;
	logic                 collecting_q, bad_q, active_q;
	logic [FCOLW-1:0]     face_color_q;
	logic signed [VW-1:0] mnx_q, mny_q, mxx_q, mxy_q;
	logic [PIXW-1:0]      box_min_x_q, box_min_y_q, box_max_x_q, box_max_y_q;
	logic [PIXW-1:0]      scan_x_q, scan_y_q;

	// current triangle
	logic [2*VW-1:0]       va_q, vb_q, vc_q;
	logic signed [LW-1:0]  lx_q [EDGES];
	logic signed [LW-1:0]  ly_q [EDGES];
	logic signed [DXW-1:0] dx0_q [EDGES];
	logic signed [DXW-1:0] dy0_q [EDGES];
	logic signed [EW-1:0]  e_row_q [EDGES];
	logic signed [EW-1:0]  e_pix_q [EDGES];
	logic signed [PW-1:0]  prod_s1;
	logic [MSELW-1:0]      sel_s1;
	logic                  vld_s1;

	// output register
	logic                 out_valid_q;
	logic [PIXW-1:0]      out_x_q, out_y_q;
	logic [WORDW-1:0]     out_word_q;
	logic                 out_cov_q, out_done_q, out_bad_q;

	// RAM
	logic [AW-1:0]        rd_addr;
	logic [2*VW-1:0]      rd_data;
	logic [CNTW-1:0]      fan_m1;

	// load logic
	logic [CNTW-1:0]      eff_count, new_count;
	logic                 store_ok, face_bad, closing;

	// step logic
	logic                 is_step, x_more, y_more, last_tri, cov;
	logic [CNTW-1:0]      fan_next;
	logic                 e_neg [EDGES];
	logic                 e_zero [EDGES];
	logic signed [EW-1:0] step_x [EDGES];
	logic signed [EW-1:0] step_y [EDGES];

	// box logic
	logic signed [VW:0]   sx_mnx, sx_mny, sum_mxx, sum_mxy;
	logic signed [VW:0]   fl_x, fl_y, cl_x, cl_y;
	logic [PIXW-1:0]      lim_x, lim_y, bmin_x, bmin_y, bmax_x, bmax_y;

	// setup logic
	logic [2*VW-1:0]       edge_a [EDGES];
	logic [2*VW-1:0]       edge_b [EDGES];
	logic [CXW-1:0]        cx0, cy0;
	logic signed [DXW-1:0] mul_a;
	logic signed [LW-1:0]  mul_b;
	logic signed [EW-1:0]  prod_ext;

	// result of the item being executed
	logic [PIXW-1:0]       o_x, o_y;
	logic [WORDW-1:0]      o_word;
	logic                  o_cov, o_done, o_bad;

	assign cfg_ready = 1'b1;

	// vertex store
	assign fan_m1 = fan_q - CNTW'(1);
	always_comb begin
		case (cmd.rd_sel)
			RD_V0:   rd_addr = '0;
			RD_PREV: rd_addr = fan_m1[AW-1:0];
			RD_CUR:  rd_addr = fan_q[AW-1:0];
			default: rd_addr = '0;
		endcase
	end

	trfr_ram #(
		.WIDTH(2 * VW),
		.DEPTH(MAX_VERTICES)
	) u_vram (
		.clk    (clk),
		.wr_en  (cmd.exec && !in_cmd_q && store_ok),
		.wr_addr(eff_count[AW-1:0]),
		.wr_data({in_x_q, in_y_q}),
		.rd_en  (cmd.rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// vertex counting on load
	always_comb begin
		eff_count = collecting_q ? count_q : '0;
		store_ok  = eff_count < CNTW'(MAX_VERTICES);
		new_count = (eff_count <= CNTW'(MAX_VERTICES)) ? eff_count + CNTW'(1) : eff_count;
		face_bad  = (new_count < CNTW'(MIN_FACE)) || (new_count > CNTW'(MAX_VERTICES));
		closing   = !in_cmd_q && in_last_q;
	end

	// pixel stepping and coverage
	always_comb begin
		is_step  = (in_cmd_q == CMD_STEP);
		x_more   = scan_x_q < box_max_x_q;
		y_more   = scan_y_q < box_max_y_q;
		fan_next = fan_q + CNTW'(1);
		last_tri = fan_next >= count_q;
		for (int e = 0; e < EDGES; e++) begin
			e_neg[e]  = e_pix_q[e][EW-1];
			e_zero[e] = (e_pix_q[e] == '0);
			step_x[e] = $signed({{(EW - LW){ly_q[e][LW-1]}}, ly_q[e]}) <<< (FRAC_BITS + 1);
			step_y[e] = $signed({{(EW - LW){lx_q[e][LW-1]}}, lx_q[e]}) <<< (FRAC_BITS + 1);
		end
		cov = (e_neg[0] == e_neg[1]) && (e_neg[1] == e_neg[2]) &&
			(e_zero[0] == e_zero[1]) && (e_zero[1] == e_zero[2]);
	end

	// status to the controller
	assign sts.close_good = closing && !face_bad;
	assign sts.tri_next   = is_step && active_q && !x_more && !y_more && !last_tri;
	assign sts.out_free   = !out_valid_q || m_tready;

	// result fields
	always_comb begin
		o_x    = '0;
		o_y    = '0;
		o_word = '0;
		o_cov  = 1'b0;
		o_done = 1'b1;
		o_bad  = bad_q;
		if (!is_step) begin
			if (closing) begin
				o_bad = face_bad;
			end
		end else if (active_q) begin
			o_x    = scan_x_q;
			o_y    = scan_y_q;
			o_word = {face_color_q, {(WORDW - FCOLW){1'b0}}};
			o_cov  = cov;
			o_done = !x_more && !y_more && last_tri;
		end
	end

	// bounding box: floor minimum, ceil maximum, clamp into the frame
	always_comb begin
		sx_mnx  = {mnx_q[VW-1], mnx_q};
		sx_mny  = {mny_q[VW-1], mny_q};
		sum_mxx = $signed({mxx_q[VW-1], mxx_q}) + $signed((VW + 1)'(ROUND_UP));
		sum_mxy = $signed({mxy_q[VW-1], mxy_q}) + $signed((VW + 1)'(ROUND_UP));
		fl_x    = sx_mnx >>> FRAC_BITS;
		fl_y    = sx_mny >>> FRAC_BITS;
		cl_x    = sum_mxx >>> FRAC_BITS;
		cl_y    = sum_mxy >>> FRAC_BITS;
		lim_x   = frame_limit(frame_w_q);
		lim_y   = frame_limit(frame_h_q);
		bmin_x  = clamp_pix(fl_x, lim_x);
		bmin_y  = clamp_pix(fl_y, lim_y);
		bmax_x  = clamp_pix(cl_x, lim_x);
		bmax_y  = clamp_pix(cl_y, lim_y);
		if (bmax_x < bmin_x) begin
			bmax_x = bmin_x;
		end
		if (bmax_y < bmin_y) begin
			bmax_y = bmin_y;
		end
	end

	// edge setup operands: edges v0->vk-1, vk-1->vk, vk->v0
	always_comb begin
		edge_a[0] = va_q;
		edge_b[0] = vb_q;
		edge_a[1] = vb_q;
		edge_b[1] = vc_q;
		edge_a[2] = vc_q;
		edge_b[2] = va_q;
		cx0 = (CXW'(box_min_x_q) << (FRAC_BITS + 1)) + CXW'(HALF_PIX);
		cy0 = (CXW'(box_min_y_q) << (FRAC_BITS + 1)) + CXW'(HALF_PIX);
		mul_a = '0;
		mul_b = '0;
		for (int e = 0; e < EDGES; e++) begin
			if (cmd.mul_sel[MSELW-1:1] == (MSELW - 1)'(e)) begin
				mul_a = cmd.mul_sel[0] ? dy0_q[e] : dx0_q[e];
				mul_b = cmd.mul_sel[0] ? lx_q[e] : ly_q[e];
			end
		end
		prod_ext = $signed({{(EW - PW){prod_s1[PW-1]}}, prod_s1});
	end

	// configuration and face control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_w_q    <= FRAME_W_RST;
			frame_h_q    <= FRAME_H_RST;
			count_q      <= '0;
			fan_q        <= CNTW'(2);
			collecting_q <= 1'b0;
			bad_q        <= 1'b0;
			active_q     <= 1'b0;
			face_color_q <= '0;
			box_min_x_q  <= '0;
			box_min_y_q  <= '0;
			box_max_x_q  <= '0;
			box_max_y_q  <= '0;
			scan_x_q     <= '0;
			scan_y_q     <= '0;
			out_valid_q  <= 1'b0;
			vld_s1       <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_FRAME_WIDTH:  frame_w_q <= cfg_data;
					CFG_FRAME_HEIGHT: frame_h_q <= cfg_data;
					default: begin
					end
				endcase
			end
			vld_s1 <= cmd.mul_en;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.exec && !is_step) begin
				if (!collecting_q) begin
					collecting_q <= 1'b1;
					active_q     <= 1'b0;
					face_color_q <= {in_r_q[NIBW-1:0], in_g_q[NIBW-1:0], in_b_q[NIBW-1:0]};
				end
				count_q <= new_count;
				if (in_last_q) begin
					collecting_q <= 1'b0;
					bad_q        <= face_bad;
					active_q     <= 1'b0;
				end
			end else if (cmd.exec && active_q) begin
				if (x_more) begin
					scan_x_q <= scan_x_q + PIXW'(1);
				end else begin
					scan_x_q <= box_min_x_q;
					if (y_more) begin
						scan_y_q <= scan_y_q + PIXW'(1);
					end else begin
						scan_y_q <= box_min_y_q;
						if (last_tri) begin
							active_q <= 1'b0;
							fan_q    <= CNTW'(2);
						end else begin
							fan_q <= fan_next;
						end
					end
				end
			end
			if (cmd.box) begin
				box_min_x_q <= bmin_x;
				box_min_y_q <= bmin_y;
				box_max_x_q <= bmax_x;
				box_max_y_q <= bmax_y;
				scan_x_q    <= bmin_x;
				scan_y_q    <= bmin_y;
				fan_q       <= CNTW'(2);
				active_q    <= 1'b1;
			end
		end
	end

	// payload: captured item, running extremes, vertices, edge functions, output
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_cmd_q  <= s_tuser[0];
			in_x_q    <= s_tdata[VW-1:0];
			in_y_q    <= s_tdata[2*VW-1:VW];
			in_r_q    <= s_tdata[2*VW+COLW-1:2*VW];
			in_g_q    <= s_tdata[2*VW+2*COLW-1:2*VW+COLW];
			in_b_q    <= s_tdata[2*VW+3*COLW-1:2*VW+2*COLW];
			in_last_q <= s_tlast;
		end
		if (cmd.exec && !is_step && store_ok) begin
			if (eff_count == '0) begin
				mnx_q <= in_x_q;
				mxx_q <= in_x_q;
				mny_q <= in_y_q;
				mxy_q <= in_y_q;
			end else begin
				if (in_x_q < mnx_q) mnx_q <= in_x_q;
				if (in_x_q > mxx_q) mxx_q <= in_x_q;
				if (in_y_q < mny_q) mny_q <= in_y_q;
				if (in_y_q > mxy_q) mxy_q <= in_y_q;
			end
		end
		case (cmd.ld_sel)
			LD_A:    va_q <= rd_data;
			LD_B:    vb_q <= rd_data;
			LD_C:    vc_q <= rd_data;
			default: begin
			end
		endcase
		if (cmd.edge_latch) begin
			for (int e = 0; e < EDGES; e++) begin
				lx_q[e]  <= $signed({($signed({edge_b[e][2*VW-1], edge_b[e][2*VW-1:VW]}) -
					$signed({edge_a[e][2*VW-1], edge_a[e][2*VW-1:VW]})), 1'b0});
				ly_q[e]  <= $signed({($signed({edge_b[e][VW-1], edge_b[e][VW-1:0]}) -
					$signed({edge_a[e][VW-1], edge_a[e][VW-1:0]})), 1'b0});
				dx0_q[e] <= $signed({{(DXW - CXW){1'b0}}, cx0}) -
					$signed({{(DXW - VW - 1){edge_a[e][2*VW-1]}}, edge_a[e][2*VW-1:VW], 1'b0});
				dy0_q[e] <= $signed({{(DXW - CXW){1'b0}}, cy0}) -
					$signed({{(DXW - VW - 1){edge_a[e][VW-1]}}, edge_a[e][VW-1:0], 1'b0});
			end
		end
		// shared multiplier, one product term per cycle
		if (cmd.mul_en) begin
			prod_s1 <= mul_a * mul_b;
			sel_s1  <= cmd.mul_sel;
		end
		// accumulate E = (cy - ay) * lx - (cx - ax) * ly at the box corner
		if (vld_s1) begin
			for (int e = 0; e < EDGES; e++) begin
				if (sel_s1[MSELW-1:1] == (MSELW - 1)'(e)) begin
					if (!sel_s1[0]) begin
						e_row_q[e] <= -prod_ext;
						e_pix_q[e] <= -prod_ext;
					end else begin
						e_row_q[e] <= e_row_q[e] + prod_ext;
						e_pix_q[e] <= e_row_q[e] + prod_ext;
					end
				end
			end
		end else if (cmd.exec && is_step && active_q) begin
			for (int e = 0; e < EDGES; e++) begin
				if (x_more) begin
					e_pix_q[e] <= e_pix_q[e] - step_x[e];
				end else if (y_more) begin
					e_row_q[e] <= e_row_q[e] + step_y[e];
					e_pix_q[e] <= e_row_q[e] + step_y[e];
				end
			end
		end
		if (cmd.exec) begin
			out_x_q    <= o_x;
			out_y_q    <= o_y;
			out_word_q <= o_word;
			out_cov_q  <= o_cov;
			out_done_q <= o_done;
			out_bad_q  <= o_bad;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{OUT_PAD{1'b0}}, out_word_q, out_y_q, out_x_q};
	assign m_tuser  = {out_bad_q, out_cov_q};
	assign m_tlast  = out_done_q;

endmodule

@@ src/triangle_fan_rasterizer_unit.sv @@
// ----------------------------------------------------------------------------
// triangle_fan_rasterizer_unit: half-space triangle fan rasterizer
// Collects a convex face of up to MAX_VERTICES vertices, then visits one
// bounding-box pixel per step beat and flags pixel-centre coverage.
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid/s_tready    tdata: vertex_x, vertex_y, red, green, blue
//                                      tuser: command   tlast: last_vertex
//   m_*      out  m_tvalid/m_tready    tdata: pixel_x, pixel_y, pixel_word
//                                      tuser: covered, bad_face   tlast: face_done
//   cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data (frame width/height)
//
// Every input beat passes through capture and execute and gives one output beat.
// A step that ends a fan triangle other than the last is followed by setup of
// the next one (3 vertex RAM reads, last vertex load, edge latch, 6 terms on the
// one shared multiplier, accumulate); a load that closes a good face is followed
// by the box clamp and the same setup.
// Reset is asynchronous; the vertex RAM is not cleared and needs no sweep.
// One result may sit in the output register while the next beat is taken;
// that beat then waits in execute until the output register drains.
// ----------------------------------------------------------------------------
module triangle_fan_rasterizer_unit
	import trfr_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // vertex_x, vertex_y, color_red, color_green, color_blue
	input  logic [IN_USER_W-1:0]  s_tuser,   // command
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // pixel_x, pixel_y, pixel_word, zero pad
	output logic [OUT_USER_W-1:0] m_tuser,   // covered, bad_face
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IW-1:0]     cfg_index,
	input  logic [DIMW-1:0]       cfg_data
);

	trfr_cmd_t cmd;
	trfr_sts_t sts;

	trfr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	trfr_dp #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

endmodule
